FILE: design/fir57_pkg.sv
// Shared types, widths and the fixed low-pass coefficient table of the 57-tap FIR filter.
package fir57_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 13;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = 32;
   localparam int NCOEF     = 57;
   localparam int TAP_IDX_W = 7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   // Control for one cell of the sample ring.
   typedef struct packed {
      logic load;
      logic rotate;
      logic clear;
   } cell_ctrl_type;

   // Control for the multiply-accumulate unit.
   typedef struct packed {
      logic vld;
      logic first;
   } mac_ctrl_type;

   localparam coef_type COEF_TAB [NCOEF] = '{
      13'sd3, 13'sd0, -13'sd7, -13'sd18, -13'sd34, -13'sd56, -13'sd81, -13'sd109,
      -13'sd136, -13'sd160, -13'sd175, -13'sd176, -13'sd158, -13'sd117, -13'sd48,
      13'sd53, 13'sd186, 13'sd351, 13'sd546, 13'sd766, 13'sd1003, 13'sd1249,
      13'sd1494, 13'sd1727, 13'sd1935, 13'sd2110, 13'sd2242, 13'sd2324, 13'sd2352,
      13'sd2324, 13'sd2242, 13'sd2110, 13'sd1935, 13'sd1727, 13'sd1494, 13'sd1249,
      13'sd1003, 13'sd766, 13'sd546, 13'sd351, 13'sd186, 13'sd53, -13'sd48,
      -13'sd117, -13'sd158, -13'sd176, -13'sd175, -13'sd160, -13'sd136, -13'sd109,
      -13'sd81, -13'sd56, -13'sd34, -13'sd18, -13'sd7, 13'sd0, 13'sd3
   };

   // Taps beyond the table have a zero coefficient.
   function automatic coef_type tap_coef(input logic [TAP_IDX_W-1:0] idx);
      coef_type c;
      if (idx < TAP_IDX_W'(NCOEF)) begin
         c = COEF_TAB[idx[5:0]];
      end else begin
         c = '0;
      end
      return c;
   endfunction

endpackage

FILE: design/fir57_cell.sv
// One cell of the sample ring: holds one sample, loads from its left or rotates from its right.
module fir57_cell
   import fir57_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl_i,
   input  sample_type    left_i,
   input  sample_type    right_i,
   output sample_type    value_o
);

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      priority if (ctrl_i.load) begin
         data_in = ctrl_i.clear ? '0 : left_i;
      end else if (ctrl_i.rotate) begin
         data_in = right_i;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign value_o = data_ff;

endmodule

FILE: design/fir57_mac.sv
// Registered multiplier and saturating 32-bit accumulator with the final rounding step.
module fir57_mac
   import fir57_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mac_ctrl_type ctrl_i,
   input  sample_type   sample_i,
   input  coef_type     coef_i,
   output sample_type   result_o
);

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic acc_type sat33(input logic signed [ACC_W:0] v);
      acc_type r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   prod_type     prod_ff;
   prod_type     prod_in;
   logic         vld_ff;
   logic         first_ff;
   acc_type      acc_ff;
   acc_type      acc_in;
   acc_type      acc_base;
   logic signed [ACC_W:0]  acc_sum;
   logic signed [ACC_W:0]  rnd_sum;
   acc_type      rnd_sat;
   logic signed [SAMPLE_W:0] shifted;

   assign prod_in  = PROD_W'(sample_i) * PROD_W'(coef_i);
   assign acc_base = first_ff ? '0 : acc_ff;
   assign acc_sum  = {acc_base[ACC_W-1], acc_base}
                   + {{(ACC_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      if (vld_ff) begin
         acc_in = sat33(acc_sum);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctrl_i.vld;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      first_ff <= ctrl_i.first;
      acc_ff   <= acc_in;
   end

   // Round half up, drop the low 16 bits, then take bits 31..15 and clamp to 16 bits.
   assign rnd_sum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(33'sh8000);
   assign rnd_sat = sat33(rnd_sum);
   assign shifted = {rnd_sat[ACC_W-1:16], 1'b0};

   always_comb begin
      if (shifted[SAMPLE_W] != shifted[SAMPLE_W-1]) begin
         result_o = shifted[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         result_o = shifted[SAMPLE_W-1:0];
      end
   end

endmodule

FILE: design/fir_filter_57tap_q15.sv
// Top level of the streaming Q15 FIR filter: sample ring, sequencer and output word register.
//
// This block filters a stream of Q15 samples with a fixed, symmetric 57-tap low-pass
// kernel and returns one filtered word for every input word. The last TAPS samples sit
// in a ring of cells; when a word is accepted the ring shifts it in at the head (and a
// set block_start flag zeroes all older samples first), then the ring rotates once per
// clock so that each sample passes a single registered multiplier, newest first. The
// products go into a 32-bit accumulator that saturates after every addition, and the
// final sum is rounded, shifted right by 15 and clamped to 16 bits. A new word is
// accepted only in the idle state, once the last word has passed the rotation through
// the multiplier, a flush state for the last accumulation and an output state that
// moves the rounded result into the output register, waiting while that register
// still holds an untaken word. The output register lets the next word be accepted
// while a result still waits on rsp_ready. After reset all stored samples read as zero.
module fir_filter_57tap_q15
   import fir57_pkg::*;
#(
   parameter int TAPS = 57
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample_in,
   input  logic       req_block_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_sample_out
);

   localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   sample_type       rsp_data_ff;
   sample_type       rsp_data_in;

   logic             accept;
   logic             cnt_last;
   logic             out_free;
   cell_ctrl_type    ring_ctrl;
   cell_ctrl_type    head_ctrl;
   mac_ctrl_type     mac_ctrl;
   coef_type         coef;
   sample_type       mac_result;
   sample_type       ring_q [TAPS];

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign cnt_last  = (cnt_ff == CNT_W'(TAPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Acceptance shifts the ring toward the tail; each run cycle rotates it toward the head.
   assign ring_ctrl.load   = accept;
   assign ring_ctrl.rotate = (state_ff == S_RUN);
   assign ring_ctrl.clear  = req_block_start;

   // The head cell always takes the new sample, so it is never cleared.
   assign head_ctrl.load   = ring_ctrl.load;
   assign head_ctrl.rotate = ring_ctrl.rotate;
   assign head_ctrl.clear  = 1'b0;

   for (genvar k = 0; k < TAPS; k++) begin : g_ring
      localparam int NEXT = (k + 1) % TAPS;
      if (k == 0) begin : g_head
         fir57_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl_i  (head_ctrl),
            .left_i  (req_sample_in),
            .right_i (ring_q[NEXT]),
            .value_o (ring_q[k])
         );
      end else begin : g_body
         fir57_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl_i  (ring_ctrl),
            .left_i  (ring_q[k-1]),
            .right_i (ring_q[NEXT]),
            .value_o (ring_q[k])
         );
      end
   end

   // The tap index follows the rotation, so the head sample meets its own coefficient.
   assign coef           = tap_coef(TAP_IDX_W'(cnt_ff));
   assign mac_ctrl.vld   = (state_ff == S_RUN);
   assign mac_ctrl.first = (cnt_ff == '0);

   fir57_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl_i   (mac_ctrl),
      .sample_i (ring_q[0]),
      .coef_i   (coef),
      .result_o (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (cnt_last) begin
               state_in = S_FLUSH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FLUSH: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            // The finished result waits here until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mac_result;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

FILE: design/fir57_checker.sv
// Port-level checks of the FIR filter handshakes and sequencing, bound to the top level.
module fir57_checker
   import fir57_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_sample_out
);

   // A stalled result word stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its value.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("result word changed while stalled");

   // One word is filtered at a time, so the input closes right after an acceptance.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again while a word is being filtered");

   // The rotation through the multiplier comes before any result appears.
   a_no_early_result : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result word appeared one cycle after acceptance");

   // Reset leaves no result word pending once it is released.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

bind fir_filter_57tap_q15 fir57_checker u_fir57_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

FILE: tb/fir_filter_57tap_q15_tb.sv
// Self-checking testbench for the streaming 57-tap Q15 FIR filter, with its own filter predictor.
module fir_filter_57tap_q15_tb;
   import fir57_pkg::*;

   // The filter length used here. It also sizes the predictor's sample history.
   localparam int TAPS       = 57;
   localparam int ITEMS      = 1750;
   // The last words of the stream go through with no idling on either side.
   localparam int QUIET_TAIL = 150;
   // The limit leaves a wide margin above the length of a correct run with its idling.
   localparam int LIMIT      = 1000000;
   localparam int END_PAUSE  = TAPS + 8;

   localparam sample_type Q15_MAX = 16'sh7FFF;
   localparam sample_type Q15_MIN = 16'sh8000;

   typedef struct packed {
      sample_type sample;
      logic       block_start;
   } sample_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   sample_type req_sample_in = '0;
   logic       req_block_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   sample_type rsp_sample_out;

   // Words waiting to be driven, and filter outputs predicted but not yet seen.
   sample_word_type pending_words [$];
   sample_type      filtered_expected [$];

   // The predictor's copy of the older samples, newest first.
   sample_type hist [TAPS-1] = '{default: '0};

   int cycles = 0;
   int errors = 0;
   int words_in = 0;
   int starts_in = 0;
   int words_out = 0;
   int clamped_out = 0;
   int gap_left = 0;
   int stall_left = 0;
   logic calm;

   fir_filter_57tap_q15 #(
      .TAPS(TAPS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_block_start(req_block_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   // Both sides stop idling near the end of the stream, and also in calm windows that recur
   // through the run, so that long stretches run at the block's full rate.
   assign calm = (pending_words.size() <= QUIET_TAIL) || ((cycles % 4096) < 512);

   // Clamp a partial sum to the signed 32-bit range of the accumulator.
   function automatic longint sat_acc(input longint v);
      longint r;
      if (v > 64'sd2147483647) begin
         r = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         r = -64'sd2147483648;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Filter one accepted word and update the sample history. The newest sample meets
   // coefficient 0, and each older one the next coefficient, with the sum clamped after
   // every step. Taps past the end of the table contribute nothing.
   function automatic sample_type fir_predict(input sample_type x, input logic start);
      longint acc;
      longint y;
      int     j;
      if (start) begin
         foreach (hist[k]) hist[k] = '0;
      end
      acc = sat_acc(longint'(x) * longint'(COEF_TAB[0]));
      for (j = 1; j < TAPS; j++) begin
         if (j < NCOEF) begin
            acc = sat_acc(acc + longint'(hist[j-1]) * longint'(COEF_TAB[j]));
         end
      end
      // Round by adding one half and dropping the low 16 bits, then rescale from the
      // product format back to Q15 and clamp.
      acc = sat_acc(acc + 64'sd32768);
      acc = acc - (acc & 64'sh0000_0000_0000_FFFF);
      y = acc >>> 15;
      if (y > 64'sd32767) y = 64'sd32767;
      if (y < -64'sd32768) y = -64'sd32768;
      for (j = TAPS - 2; j > 0; j--) begin
         hist[j] = hist[j-1];
      end
      hist[0] = x;
      return sample_type'(y);
   endfunction

   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      $display("mismatch at cycle %0d, output word %0d: %s, got %0d, expected %0d",
               cycles, words_out, what, got, want);
      errors++;
   endtask

   task automatic add_word(input sample_type x, input logic start);
      sample_word_type w;
      w.sample      = x;
      w.block_start = start;
      pending_words.push_back(w);
   endtask

   // Input side. Each accepted word is filtered by the predictor at once. A new word is
   // put up only when the channel is free; otherwise the current one is held unchanged.
   // Every branch below gives each driven signal at most one assignment.
   always @(posedge clock) begin : drive_words
      sample_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            filtered_expected.push_back(fir_predict(req_sample_in, req_block_start));
            words_in++;
            if (req_block_start) starts_in++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
               // An idle burst of random length, this one included.
               req_valid <= 1'b0;
               gap_left  <= $urandom_range(0, 2);
            end else begin
               w = pending_words.pop_front();
               req_valid       <= 1'b1;
               req_sample_in   <= w.sample;
               req_block_start <= w.block_start;
            end
         end
      end
   end

   // Output side. Every accepted word is compared with the oldest prediction, and
   // rsp_ready drops in short random bursts outside the calm stretches.
   always @(posedge clock) begin : watch_words
      sample_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (filtered_expected.size() == 0) begin
               report_mismatch("output word with no input pending", rsp_sample_out, '0);
            end else begin
               want = filtered_expected.pop_front();
               if (rsp_sample_out !== want) begin
                  report_mismatch("sample_out differs", rsp_sample_out, want);
               end
            end
            if (rsp_sample_out == Q15_MAX || rsp_sample_out == Q15_MIN) clamped_out++;
            words_out++;
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int         total;
      int         len;
      int         mode;
      int         m;
      logic       hi;
      logic       neg;
      sample_type x;

      // Directed words: the field extremes, block starts right after large samples so that
      // a missed clear shows up at once, impulses of both signs and alternating bit
      // patterns.
      add_word('0, 1'b1);
      add_word(Q15_MAX, 1'b0);
      add_word('0, 1'b0);
      add_word('0, 1'b0);
      add_word('0, 1'b0);
      add_word(Q15_MIN, 1'b1);
      add_word(Q15_MIN, 1'b0);
      add_word(Q15_MIN, 1'b0);
      add_word(Q15_MIN, 1'b0);
      add_word(Q15_MAX, 1'b0);
      add_word(Q15_MIN, 1'b0);
      add_word(Q15_MAX, 1'b0);
      add_word(Q15_MIN, 1'b0);
      add_word(16'sd1, 1'b1);
      add_word(-16'sd1, 1'b0);
      add_word(16'sh5555, 1'b0);
      add_word(16'shAAAA, 1'b0);
      add_word(-16'sd1, 1'b1);
      add_word(16'sd1, 1'b0);
      add_word(Q15_MAX, 1'b1);
      add_word(Q15_MAX, 1'b0);
      add_word('0, 1'b1);
      total = pending_words.size();

      // Random words in segments of differing character.
      while (total < ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode <= 3) begin
            // Full-range noise with an occasional block start.
            len = $urandom_range(8, 48);
            for (m = 0; m < len; m++) begin
               add_word(sample_type'($urandom_range(0, 65535)), $urandom_range(0, 15) == 0);
            end
         end else if (mode <= 5) begin
            // A block whose samples follow the coefficient signs at full scale. The last
            // word of it drives the output past the 16-bit range, upward or downward.
            neg = $urandom_range(0, 1);
            len = NCOEF;
            for (m = 0; m < len; m++) begin
               hi = (COEF_TAB[m] == 0) ? logic'($urandom_range(0, 1)) : (COEF_TAB[m] > 0);
               if (neg) hi = !hi;
               x = hi ? sample_type'(32767 - int'($urandom_range(0, 63)))
                      : sample_type'(-32768 + int'($urandom_range(0, 63)));
               add_word(x, m == 0);
            end
         end else if (mode == 6) begin
            // A full-scale constant level, which settles near the clamp limit.
            neg = $urandom_range(0, 1);
            len = $urandom_range(60, 70);
            for (m = 0; m < len; m++) begin
               add_word(neg ? Q15_MIN : Q15_MAX, m == 0);
            end
         end else if (mode <= 8) begin
            // Small samples, where the rounding step decides most outputs.
            len = $urandom_range(16, 64);
            for (m = 0; m < len; m++) begin
               add_word(sample_type'(int'($urandom_range(0, 511)) - 256),
                        $urandom_range(0, 15) == 0);
            end
         end else begin
            // Short blocks with frequent restarts.
            len = $urandom_range(4, 12);
            for (m = 0; m < len; m++) begin
               add_word(sample_type'($urandom_range(0, 65535)), $urandom_range(0, 1) == 1);
            end
         end
         total += len;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Run until every word has gone in and every prediction has been met, then give
      // the block one more pass through its pipeline in case it emits a stray word.
      while (cycles < LIMIT &&
             (pending_words.size() > 0 || req_valid || filtered_expected.size() > 0)) begin
         @(posedge clock);
      end
      repeat (END_PAUSE) @(posedge clock);

      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles with %0d words still expected",
                  cycles, filtered_expected.size());
         $display("== FAIL ==");
      end else begin
         $display("Filtered %0d input words (%0d opening a new block) into %0d output words,",
                  words_in, starts_in, words_out);
         $display("%0d of them at a clamp limit, with %0d mismatches in %0d cycles.",
                  clamped_out, errors, cycles);
         if (errors == 0) begin
            $display("== PASS ==");
         end else begin
            $display("== FAIL ==");
         end
      end
      $finish;
   end

endmodule
